// ----- rtl/core/gmb_pkg.sv -----
// gmb_pkg: shared constants and codes for the grid BFS path block.
// No dependencies; used by the interfaces, the RAM users and the top level.
package gmb_pkg;

    // grid capacity
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CELL_W   = ROW_W + COL_W;
    localparam int POS_W    = CELL_W + 1;

    // field widths
    localparam int CFG_W    = 6;
    localparam int DIST_W   = 10;
    localparam int IDX_W    = 10;
    localparam int DIR_W    = 2;
    localparam int KIND_W   = 2;

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result kinds
    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_MOVE   = 1'b1;

    // cell kinds
    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd3;

    // move directions, in expansion order
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

endpackage

// ----- rtl/core/gmb_if.sv -----
// gmb_if: valid/ready channel interfaces for input and result items.
// Depends on gmb_pkg for field widths.
interface gmb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [gmb_pkg::KIND_W-1:0]  cell_kind;
    logic [gmb_pkg::IDX_W-1:0]   step_index;

    modport source (output valid, op, cell_kind, step_index, input ready);
    modport sink   (input valid, op, cell_kind, step_index, output ready);
endinterface

interface gmb_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic                        found;
    logic [gmb_pkg::DIST_W-1:0]  distance;
    logic [gmb_pkg::DIR_W-1:0]   move;
    logic                        in_range;

    modport source (output valid, result_kind, found, distance, move, in_range,
                    input ready);
    modport sink   (input valid, result_kind, found, distance, move, in_range,
                    output ready);
endinterface

// ----- rtl/core/grid_maze_bfs_path.sv -----
// grid_maze_bfs_path: grid loader, breadth-first search and path store.
// Depends on gmb_pkg, gmb_if (channels) and gmb_ram (cell state memories).
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   op, cell_kind, step_index
//  out_ch    out   valid/ready   result_kind, found, distance, move, in_range
//  cfg       in    cfg_we        cfg_index, cfg_data (rows, cols)
//
// A load passes through S_LOAD; the first load after a cols/rows write that
// does not start a new grid also runs a subtract-by-cols loop (S_DIV), one
// subtraction per full row before the load position, to place the cell.
// If a start and a goal were loaded, the last load runs the search: each
// reached cell is popped from the queue (S_POP, S_POPW), each neighbor is
// checked (S_NB, plus S_NBW inside the grid), then two traceback passes follow.
// A read goes through S_RD (move memory read). Reset clears all control state;
// no memory clearing is needed, since each load clears that cell's visit mark.
// A new item is taken only once the previous result has left the output.
module grid_maze_bfs_path (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0]   cfg_data,
    gmb_in_if.sink                      in_ch,
    gmb_out_if.source                   out_ch
);

    localparam int CW = gmb_pkg::CELL_W;
    localparam int RW = gmb_pkg::ROW_W;
    localparam int OW = gmb_pkg::COL_W;
    localparam int PW = gmb_pkg::POS_W;
    localparam int FW = gmb_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LOAD, S_INIT, S_POP, S_POPW, S_NB, S_NBW,
        S_CHK, S_CHKW, S_CNT, S_CNTW, S_ST, S_STW, S_RD
    } state_t;

    state_t                        state_reg;
    logic [FW-1:0]                 rows_reg, cols_reg;
    logic                          remap_reg;
    logic [PW-1:0]                 pos_reg, rem_reg;
    logic [RW-1:0]                 lrow_reg;
    logic [OW-1:0]                 lcol_reg;
    logic [gmb_pkg::KIND_W-1:0]    kind_reg;
    logic [CW-1:0]                 start_reg, goal_reg;
    logic                          start_seen_reg, goal_seen_reg;
    logic                          found_reg;
    logic [gmb_pkg::DIST_W-1:0]    plen_reg;
    logic [PW-1:0]                 head_reg, tail_reg;
    logic [CW-1:0]                 cur_reg, nxt_reg, at_reg;
    logic [gmb_pkg::DIR_W-1:0]     dir_reg;
    logic [PW-1:0]                 len_reg, k_reg;
    logic                          ok_reg;

    logic                          out_valid_reg, out_kind_reg, out_found_reg;
    logic [gmb_pkg::DIST_W-1:0]    out_dist_reg;
    logic [gmb_pkg::DIR_W-1:0]     out_move_reg;
    logic                          out_range_reg;

    // memory ports
    logic                          wall_we, vis_we, par_we, q_we, mv_we;
    logic [CW-1:0]                 wall_addr, vis_addr, par_addr, q_addr, mv_addr;
    logic                          wall_wd, vis_wd, wall_rd, vis_rd;
    logic [gmb_pkg::DIR_W-1:0]     par_wd, par_rd, mv_wd, mv_rd;
    logic [CW-1:0]                 q_wd, q_rd;

    // clamped grid size and cell count
    logic [FW-1:0]                 nr, nc;
    logic [2*FW-1:0]               total;
    logic                          in_fire, restart, last_load;
    logic [CW-1:0]                 load_cell;

    always_comb
    begin
        nr = (rows_reg == '0) ? FW'(1) :
             (rows_reg > FW'(gmb_pkg::MAX_ROWS)) ? FW'(gmb_pkg::MAX_ROWS) : rows_reg;
        nc = (cols_reg == '0) ? FW'(1) :
             (cols_reg > FW'(gmb_pkg::MAX_COLS)) ? FW'(gmb_pkg::MAX_COLS) : cols_reg;
        total     = (2*FW)'(nr) * (2*FW)'(nc);
        restart   = (2*FW)'(pos_reg) >= total;
        last_load = (2*FW)'(pos_reg) + (2*FW)'(1) >= total;
        load_cell = {lrow_reg, lcol_reg};
    end

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;

    // neighbor of the cell being expanded
    logic [RW-1:0] cur_r, at_r;
    logic [OW-1:0] cur_c, at_c;
    logic          nb_ok;
    logic [CW-1:0] nb_cell, back_cell;

    always_comb
    begin
        cur_r = cur_reg[CW-1:OW];
        cur_c = cur_reg[OW-1:0];
        nb_ok   = 1'b0;
        nb_cell = cur_reg;
        unique case (dir_reg)
            gmb_pkg::DIR_RIGHT:
            begin
                nb_ok   = (FW'(cur_c) + FW'(1)) < nc;
                nb_cell = {cur_r, cur_c + OW'(1)};
            end
            gmb_pkg::DIR_LEFT:
            begin
                nb_ok   = cur_c != '0;
                nb_cell = {cur_r, cur_c - OW'(1)};
            end
            gmb_pkg::DIR_UP:
            begin
                nb_ok   = cur_r != '0;
                nb_cell = {cur_r - RW'(1), cur_c};
            end
            gmb_pkg::DIR_DOWN:
            begin
                nb_ok   = (FW'(cur_r) + FW'(1)) < nr;
                nb_cell = {cur_r + RW'(1), cur_c};
            end
        endcase
    end

    // step back against the recorded entry direction
    always_comb
    begin
        at_r = at_reg[CW-1:OW];
        at_c = at_reg[OW-1:0];
        unique case (par_rd)
            gmb_pkg::DIR_RIGHT: back_cell = {at_r, at_c - OW'(1)};
            gmb_pkg::DIR_LEFT:  back_cell = {at_r, at_c + OW'(1)};
            gmb_pkg::DIR_UP:    back_cell = {at_r + RW'(1), at_c};
            gmb_pkg::DIR_DOWN:  back_cell = {at_r - RW'(1), at_c};
        endcase
    end

    logic new_cell;
    assign new_cell = !wall_rd && !vis_rd;

    // memory addressing per state
    always_comb
    begin
        wall_we = 1'b0; wall_addr = load_cell; wall_wd = kind_reg == gmb_pkg::KIND_WALL;
        vis_we  = 1'b0; vis_addr  = load_cell; vis_wd  = 1'b0;
        par_we  = 1'b0; par_addr  = at_reg;    par_wd  = dir_reg;
        q_we    = 1'b0; q_addr    = head_reg[CW-1:0]; q_wd = nxt_reg;
        mv_we   = 1'b0; mv_addr   = in_ch.step_index[CW-1:0]; mv_wd = par_rd;
        unique case (state_reg)
            S_LOAD:
            begin
                wall_we = 1'b1;
                vis_we  = 1'b1;
            end
            S_INIT:
            begin
                vis_we   = start_seen_reg && goal_seen_reg;
                vis_addr = start_reg;
                vis_wd   = 1'b1;
                q_we     = vis_we;
                q_addr   = '0;
                q_wd     = start_reg;
            end
            S_NB:
            begin
                wall_addr = nb_cell;
                vis_addr  = nb_cell;
            end
            S_NBW:
            begin
                vis_we   = new_cell;
                vis_addr = nxt_reg;
                vis_wd   = 1'b1;
                par_we   = new_cell;
                par_addr = nxt_reg;
                q_we     = new_cell && (tail_reg < PW'(gmb_pkg::CELLS));
                q_addr   = tail_reg[CW-1:0];
            end
            S_CHK:
            begin
                vis_addr = goal_reg;
            end
            S_STW:
            begin
                mv_we   = 1'b1;
                mv_addr = CW'(k_reg - PW'(1));
            end
            default:
            begin
            end
        endcase
    end

    gmb_ram #(.WIDTH(1), .DEPTH(gmb_pkg::CELLS)) u_wall (
        .clk(clk), .we(wall_we), .addr(wall_addr), .wdata(wall_wd), .rdata(wall_rd));
    gmb_ram #(.WIDTH(1), .DEPTH(gmb_pkg::CELLS)) u_vis (
        .clk(clk), .we(vis_we), .addr(vis_addr), .wdata(vis_wd), .rdata(vis_rd));
    gmb_ram #(.WIDTH(gmb_pkg::DIR_W), .DEPTH(gmb_pkg::CELLS)) u_par (
        .clk(clk), .we(par_we), .addr(par_addr), .wdata(par_wd), .rdata(par_rd));
    gmb_ram #(.WIDTH(CW), .DEPTH(gmb_pkg::CELLS)) u_queue (
        .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));
    gmb_ram #(.WIDTH(gmb_pkg::DIR_W), .DEPTH(gmb_pkg::CELLS)) u_move (
        .clk(clk), .we(mv_we), .addr(mv_addr), .wdata(mv_wd), .rdata(mv_rd));

    // sequencer, registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rows_reg       <= FW'(32);
            cols_reg       <= FW'(32);
            remap_reg      <= 1'b0;
            pos_reg        <= '0;
            lrow_reg       <= '0;
            lcol_reg       <= '0;
            start_reg      <= '0;
            goal_reg       <= '0;
            start_seen_reg <= 1'b0;
            goal_seen_reg  <= 1'b0;
            found_reg      <= 1'b0;
            plen_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                remap_reg <= 1'b1;
                unique case (cfg_index)
                    gmb_pkg::REG_ROWS: rows_reg <= cfg_data;
                    gmb_pkg::REG_COLS: cols_reg <= cfg_data;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.op == gmb_pkg::OP_READ)
                    begin
                        ok_reg    <= found_reg && (in_ch.step_index < plen_reg);
                        state_reg <= S_RD;
                    end
                    else if (in_fire)
                    begin
                        kind_reg <= in_ch.cell_kind;
                        if (restart)
                        begin
                            pos_reg        <= '0;
                            lrow_reg       <= '0;
                            lcol_reg       <= '0;
                            start_seen_reg <= 1'b0;
                            goal_seen_reg  <= 1'b0;
                            remap_reg      <= 1'b0;
                            state_reg      <= S_LOAD;
                        end
                        else if (remap_reg)
                        begin
                            rem_reg   <= pos_reg;
                            lrow_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_DIV:
                begin
                    // row and column of the load position under the new width
                    if (rem_reg >= PW'(nc))
                    begin
                        rem_reg  <= rem_reg - PW'(nc);
                        lrow_reg <= lrow_reg + RW'(1);
                    end
                    else
                    begin
                        lcol_reg  <= OW'(rem_reg);
                        remap_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (kind_reg == gmb_pkg::KIND_START)
                    begin
                        start_reg      <= load_cell;
                        start_seen_reg <= 1'b1;
                    end
                    if (kind_reg == gmb_pkg::KIND_GOAL)
                    begin
                        goal_reg      <= load_cell;
                        goal_seen_reg <= 1'b1;
                    end
                    if (last_load)
                    begin
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PW'(1);
                        if (FW'(lcol_reg) + FW'(1) == nc)
                        begin
                            lcol_reg <= '0;
                            lrow_reg <= lrow_reg + RW'(1);
                        end
                        else
                        begin
                            lcol_reg <= lcol_reg + OW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_INIT:
                begin
                    pos_reg  <= '0;
                    lrow_reg <= '0;
                    lcol_reg <= '0;
                    head_reg <= '0;
                    tail_reg <= PW'(1);
                    if (start_seen_reg && goal_seen_reg)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        plen_reg  <= '0;
                        len_reg   <= '0;
                        state_reg <= S_ST;
                        k_reg     <= '0;
                    end
                end
                S_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        head_reg  <= head_reg + PW'(1);
                        state_reg <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    cur_reg   <= q_rd;
                    dir_reg   <= gmb_pkg::DIR_RIGHT;
                    state_reg <= S_NB;
                end
                S_NB:
                begin
                    if (nb_ok)
                    begin
                        nxt_reg   <= nb_cell;
                        state_reg <= S_NBW;
                    end
                    else if (dir_reg == gmb_pkg::DIR_DOWN)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        dir_reg <= dir_reg + gmb_pkg::DIR_W'(1);
                    end
                end
                S_NBW:
                begin
                    if (new_cell && (tail_reg < PW'(gmb_pkg::CELLS)))
                    begin
                        tail_reg <= tail_reg + PW'(1);
                    end
                    if (dir_reg == gmb_pkg::DIR_DOWN)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        dir_reg   <= dir_reg + gmb_pkg::DIR_W'(1);
                        state_reg <= S_NB;
                    end
                end
                S_CHK:
                begin
                    state_reg <= S_CHKW;
                end
                S_CHKW:
                begin
                    at_reg  <= goal_reg;
                    len_reg <= '0;
                    if (vis_rd)
                    begin
                        state_reg <= S_CNT;
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        plen_reg  <= '0;
                        k_reg     <= '0;
                        state_reg <= S_ST;
                    end
                end
                // first pass: count moves back to the start
                S_CNT:
                begin
                    if (at_reg == start_reg)
                    begin
                        at_reg    <= goal_reg;
                        k_reg     <= len_reg;
                        found_reg <= 1'b1;
                        plen_reg  <= gmb_pkg::DIST_W'(len_reg);
                        state_reg <= S_ST;
                    end
                    else
                    begin
                        state_reg <= S_CNTW;
                    end
                end
                S_CNTW:
                begin
                    at_reg    <= back_cell;
                    len_reg   <= len_reg + PW'(1);
                    state_reg <= S_CNT;
                end
                // second pass: store moves from the end of the path
                S_ST:
                begin
                    if (k_reg == '0)
                    begin
                        start_seen_reg <= 1'b0;
                        goal_seen_reg  <= 1'b0;
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= gmb_pkg::RES_REPORT;
                        out_found_reg  <= found_reg;
                        out_dist_reg   <= found_reg ? plen_reg : '0;
                        out_move_reg   <= gmb_pkg::DIR_RIGHT;
                        out_range_reg  <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_STW;
                    end
                end
                S_STW:
                begin
                    at_reg    <= back_cell;
                    k_reg     <= k_reg - PW'(1);
                    state_reg <= S_ST;
                end
                S_RD:
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= gmb_pkg::RES_MOVE;
                    out_found_reg <= found_reg;
                    out_dist_reg  <= found_reg ? plen_reg : '0;
                    out_move_reg  <= ok_reg ? mv_rd : gmb_pkg::DIR_RIGHT;
                    out_range_reg <= ok_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_kind = out_kind_reg;
    assign out_ch.found       = out_found_reg;
    assign out_ch.distance    = out_dist_reg;
    assign out_ch.move        = out_move_reg;
    assign out_ch.in_range    = out_range_reg;

    // checks on the sequencer
    a_read_goes_rd: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.op == gmb_pkg::OP_READ |=> state_reg == S_RD)
        else $error("read item did not enter move read");
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("result pending during search");
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_range_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_range_reg |-> out_found_reg && out_kind_reg == gmb_pkg::RES_MOVE)
        else $error("in-range move without a found path");

endmodule

// ----- rtl/core/gmb_ram.sv -----
// gmb_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module gmb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, and read the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
